// ===== sv/uvts_pkg.sv =====
package uvts_pkg;

   localparam int OP_W      = 2;
   localparam int ADDR_W    = 14;
   localparam int WDATA_W   = 12;
   localparam int UV_W      = 16;
   localparam int LIGHT_W   = 8;
   localparam int PIXEL_W   = 16;
   localparam int OFFSET_W  = 14;
   localparam int COLOR_W   = 8;
   localparam int LEVEL_W   = 5;
   localparam int SHADE_LEVELS = 32;

   // Offset plus half the UV word never exceeds 16 bits.
   localparam int SUM_W     = 16;

   localparam int TEXELS_DEFAULT         = 16384;
   localparam int PALETTE_COLORS_DEFAULT = 256;

   typedef enum logic [OP_W-1:0] {
      OP_WR_TEXEL = 2'd0,
      OP_WR_SHADE = 2'd1,
      OP_RENDER   = 2'd2
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [ADDR_W-1:0]    address;
      logic [WDATA_W-1:0]   write_data;
      logic                 skip;
      logic [LEVEL_W-1:0]   level;
   } stage_type;

   // Bit k of each nibble lands in nibble k of the word as {r, g, b, b}.
   function automatic logic [PIXEL_W-1:0] interleave_rgb(input logic [WDATA_W-1:0] rgb);
      logic [PIXEL_W-1:0] w;
      w = '0;
      for (int k = 0; k < 4; k++) begin
         w[4*k+3] = rgb[8+k];
         w[4*k+2] = rgb[4+k];
         w[4*k+1] = rgb[k];
         w[4*k]   = rgb[k];
      end
      return w;
   endfunction

endpackage

// ===== sv/uv_texture_light_shader.sv =====
// Channel | Direction | Signals
// req     | in        | req_valid/req_ready, op, address, write_data, uv_code, light_raw
// rsp     | out       | rsp_valid/rsp_ready, pixel_value, pixel_written
// csr     | in        | csr_valid/csr_ready (always ready), texture_offset
//
// One transaction per clock while the skid register is empty (req_ready is low otherwise).
// Six pipeline stages: texel index sum, reciprocal multiply, quotient, remainder,
// texel memory read, shade memory read; then the output register.
// Writes happen in the stage where that memory is read, so order is kept.
// A stall at rsp parks one result in a skid register and freezes the pipeline.
// Reset clears the valid bits and texture_offset; the memories hold no reset value.
module uv_texture_light_shader #(
   parameter int TEXELS         = uvts_pkg::TEXELS_DEFAULT,
   parameter int PALETTE_COLORS = uvts_pkg::PALETTE_COLORS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [uvts_pkg::OP_W-1:0]      req_op,
   input  logic [uvts_pkg::ADDR_W-1:0]    req_address,
   input  logic [uvts_pkg::WDATA_W-1:0]   req_write_data,
   input  logic [uvts_pkg::UV_W-1:0]      req_uv_code,
   input  logic [uvts_pkg::LIGHT_W-1:0]   req_light_raw,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [uvts_pkg::PIXEL_W-1:0]   rsp_pixel_value,
   output logic                           rsp_pixel_written,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [uvts_pkg::OFFSET_W-1:0]  csr_texture_offset
);

   localparam int SUM_W       = uvts_pkg::SUM_W;
   localparam int TIDX_W      = $clog2(TEXELS);
   localparam int SHADE_DEPTH = PALETTE_COLORS * uvts_pkg::SHADE_LEVELS;
   localparam int SIDX_W      = $clog2(SHADE_DEPTH);
   localparam longint unsigned RECIP = (64'd1 << 32) / TEXELS;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int Q_W         = PROD_W - 32;

   logic [uvts_pkg::OFFSET_W-1:0] offset_ff;

   logic pipe_en;
   logic req_fire;

   uvts_pkg::stage_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s1_in;
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;
   logic s6_render_ff, s6_skip_ff, s6_pal_ok_ff, s6_pal_ok_in;

   logic [SUM_W-1:0]  s1_sum_ff, s1_sum_in, s2_sum_ff, s3_sum_ff;
   logic [PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic [Q_W-1:0]    s3_q_ff, s3_q_in;
   logic [31:0]       s4_qt;
   logic [SUM_W-1:0]  s4_rem_ff, s4_rem_in;
   logic [31:0]       s4_rem_fix;

   logic                          texel_we, texel_re;
   logic [TIDX_W-1:0]             texel_waddr, texel_raddr;
   logic [uvts_pkg::COLOR_W-1:0]  color_rd;

   logic                          shade_we, shade_re;
   logic [SIDX_W-1:0]             shade_waddr, shade_raddr;
   logic [uvts_pkg::PIXEL_W-1:0]  shade_wdata, shade_rd;

   logic                          push;
   logic [uvts_pkg::PIXEL_W-1:0]  push_value;
   logic                          out_vld_ff, skid_vld_ff;
   logic [uvts_pkg::PIXEL_W-1:0]  out_value_ff, skid_value_ff;
   logic                          out_written_ff, skid_written_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_valid) begin
         offset_ff <= csr_texture_offset;
      end
   end

   // The pipeline only moves while the skid register is empty.
   assign pipe_en   = !skid_vld_ff;
   assign req_ready = pipe_en;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_in.op         = uvts_pkg::op_type'(req_op);
      s1_in.address    = req_address;
      s1_in.write_data = req_write_data;
      s1_in.skip       = req_uv_code[0];
      s1_in.level      = req_light_raw[7:3];
      s1_sum_in        = SUM_W'(offset_ff) + SUM_W'(req_uv_code[uvts_pkg::UV_W-1:1]);
   end

   // Texel index modulo TEXELS: the floor reciprocal gives a quotient that is exact
   // or one short, so the remainder is below twice TEXELS and one subtract fixes it.
   assign s2_prod_in = PROD_W'(s1_sum_ff) * PROD_W'(RECIP);
   assign s3_q_in    = s2_prod_ff[PROD_W-1:32];
   assign s4_qt      = 32'(s3_q_ff) * 32'(TEXELS);
   assign s4_rem_in  = s3_sum_ff - s4_qt[SUM_W-1:0];
   assign s4_rem_fix = (32'(s4_rem_ff) >= 32'(TEXELS)) ? 32'(s4_rem_ff) - 32'(TEXELS)
                                                       : 32'(s4_rem_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_ff      <= s1_in;
         s1_sum_ff  <= s1_sum_in;
         s2_ff      <= s1_ff;
         s2_sum_ff  <= s1_sum_ff;
         s2_prod_ff <= s2_prod_in;
         s3_ff      <= s2_ff;
         s3_sum_ff  <= s2_sum_ff;
         s3_q_ff    <= s3_q_in;
         s4_ff      <= s3_ff;
         s4_rem_ff  <= s4_rem_in;
         s5_ff      <= s4_ff;
         s6_render_ff <= (s5_ff.op == uvts_pkg::OP_RENDER);
         s6_skip_ff   <= s5_ff.skip;
         s6_pal_ok_ff <= s6_pal_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff <= req_fire;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   assign texel_we    = pipe_en && s4_vld_ff && (s4_ff.op == uvts_pkg::OP_WR_TEXEL)
                        && (32'(s4_ff.address) < 32'(TEXELS));
   assign texel_waddr = TIDX_W'(s4_ff.address);
   assign texel_re    = pipe_en && s4_vld_ff;
   assign texel_raddr = s4_rem_fix[TIDX_W-1:0];

   uvts_ram #(
      .WIDTH (uvts_pkg::COLOR_W),
      .DEPTH (TEXELS)
   ) u_texel_ram (
      .clock   (clock),
      .wr_en   (texel_we),
      .wr_addr (texel_waddr),
      .wr_data (s4_ff.write_data[uvts_pkg::COLOR_W-1:0]),
      .rd_en   (texel_re),
      .rd_addr (texel_raddr),
      .rd_data (color_rd)
   );

   assign s6_pal_ok_in = (32'(color_rd) < 32'(PALETTE_COLORS));
   assign shade_we     = pipe_en && s5_vld_ff && (s5_ff.op == uvts_pkg::OP_WR_SHADE)
                         && (32'(s5_ff.address) < 32'(SHADE_DEPTH));
   assign shade_waddr  = SIDX_W'(s5_ff.address);
   assign shade_wdata  = uvts_pkg::interleave_rgb(s5_ff.write_data);
   assign shade_re     = pipe_en && s5_vld_ff;
   assign shade_raddr  = SIDX_W'({color_rd, s5_ff.level});

   uvts_ram #(
      .WIDTH (uvts_pkg::PIXEL_W),
      .DEPTH (SHADE_DEPTH)
   ) u_shade_ram (
      .clock   (clock),
      .wr_en   (shade_we),
      .wr_addr (shade_waddr),
      .wr_data (shade_wdata),
      .rd_en   (shade_re),
      .rd_addr (shade_raddr),
      .rd_data (shade_rd)
   );

   assign push       = pipe_en && s6_vld_ff && s6_render_ff;
   assign push_value = (s6_skip_ff || !s6_pal_ok_ff) ? '0 : shade_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_vld_ff && !rsp_ready) begin
         if (push) begin
            skid_vld_ff <= 1'b1;
         end
      end else if (skid_vld_ff) begin
         out_vld_ff  <= 1'b1;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (out_vld_ff && !rsp_ready) begin
         if (push) begin
            skid_value_ff   <= push_value;
            skid_written_ff <= !s6_skip_ff;
         end
      end else if (skid_vld_ff) begin
         out_value_ff   <= skid_value_ff;
         out_written_ff <= skid_written_ff;
      end else if (push) begin
         out_value_ff   <= push_value;
         out_written_ff <= !s6_skip_ff;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_pixel_value   = out_value_ff;
   assign rsp_pixel_written = out_written_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register holds a result while the output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(out_vld_ff && !rsp_ready))
      else $error("skid register filled without a stalled output");

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pixel_written) |-> (rsp_pixel_value == '0))
      else $error("skipped pixel carries a nonzero value");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      s4_vld_ff |-> (32'(s4_rem_ff) < 2 * 32'(TEXELS)))
      else $error("texel index remainder out of correction range");

endmodule

// ===== sv/uvts_ram.sv =====
module uvts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_uv_texture_light_shader.sv =====
module tb_uv_texture_light_shader;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OP_W         = uvts_pkg::OP_W;
   localparam int ADDR_W       = uvts_pkg::ADDR_W;
   localparam int WDATA_W      = uvts_pkg::WDATA_W;
   localparam int UV_W         = uvts_pkg::UV_W;
   localparam int LIGHT_W      = uvts_pkg::LIGHT_W;
   localparam int PIXEL_W      = uvts_pkg::PIXEL_W;
   localparam int OFFSET_W     = uvts_pkg::OFFSET_W;
   localparam int COLOR_W      = uvts_pkg::COLOR_W;
   localparam int SHADE_LEVELS = uvts_pkg::SHADE_LEVELS;

   localparam int N_TEXELS = uvts_pkg::TEXELS_DEFAULT;
   localparam int N_SHADES = uvts_pkg::PALETTE_COLORS_DEFAULT * SHADE_LEVELS;
   localparam int ADDR_MAX = (1 << ADDR_W) - 1;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int MAX_WAIT = 14;
   localparam int PIPE_FLUSH = 12;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic [PIXEL_W-1:0] value;
      logic               written;
   } shaded_pixel_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_op = '0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [WDATA_W-1:0]  req_write_data = '0;
   logic [UV_W-1:0]     req_uv_code = '0;
   logic [LIGHT_W-1:0]  req_light_raw = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [PIXEL_W-1:0]  rsp_pixel_value;
   logic                rsp_pixel_written;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [OFFSET_W-1:0] csr_texture_offset = '0;

   // Shadow of the block, updated on accepted writes, renders and offset changes.
   logic [COLOR_W-1:0]  shadow_texel [N_TEXELS];
   logic [PIXEL_W-1:0]  shadow_shade [N_SHADES];
   logic [OFFSET_W-1:0] shadow_offset = '0;
   shaded_pixel_type    pending_pixels [$];
   int                  mismatch_count = 0;

   // What the stimulus has written so far, so that no render reads an unwritten entry.
   bit                  texel_set [N_TEXELS];
   logic [COLOR_W-1:0]  texel_plan [N_TEXELS];
   bit                  shade_set [N_SHADES];
   int                  texel_list [$];
   int                  scroll_offset = 0;

   int                  req_wait_max = MAX_WAIT;
   int                  rsp_wait_max = MAX_WAIT;
   int                  rsp_wait = 0;
   logic                rsp_hold = 1'b0;
   int                  idle_cycles = 0;
   event                hold_rsp_ev;

   uv_texture_light_shader uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_address        (req_address),
      .req_write_data     (req_write_data),
      .req_uv_code        (req_uv_code),
      .req_light_raw      (req_light_raw),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_pixel_written  (rsp_pixel_written),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_texture_offset (csr_texture_offset)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [PIXEL_W-1:0] interleave_color(input logic [WDATA_W-1:0] rgb);
      logic [PIXEL_W-1:0] r, g, b;
      r = '0;
      g = '0;
      b = '0;
      for (int k = 0; k < 4; k++) begin
         r[4*k] = rgb[8+k];
         g[4*k] = rgb[4+k];
         b[4*k] = rgb[k];
      end
      // The spread nibbles never overlap, so the weighted sum has no carries.
      return (r << 3) + (g << 2) + b * PIXEL_W'(3);
   endfunction

   always @(posedge clock) begin : scoreboard
      shaded_pixel_type want;
      int tidx, sidx;
      if (reset) begin
         shadow_offset = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $display("%0t: unexpected pixel, expected none, actual value %h written %b",
                        $time, rsp_pixel_value, rsp_pixel_written);
               mismatch_count++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel_value !== want.value) begin
                  $display("%0t: pixel_value expected %h actual %h",
                           $time, want.value, rsp_pixel_value);
                  mismatch_count++;
               end
               if (rsp_pixel_written !== want.written) begin
                  $display("%0t: pixel_written expected %b actual %b",
                           $time, want.written, rsp_pixel_written);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) shadow_offset = csr_texture_offset;
         if (req_valid && req_ready) begin
            case (req_op)
               uvts_pkg::OP_WR_TEXEL: shadow_texel[req_address] = req_write_data[COLOR_W-1:0];
               uvts_pkg::OP_WR_SHADE: begin
                  if (req_address < N_SHADES)
                     shadow_shade[req_address] = interleave_color(req_write_data);
               end
               uvts_pkg::OP_RENDER: begin
                  if (req_uv_code[0]) begin
                     want.value = '0;
                     want.written = 1'b0;
                  end else begin
                     tidx = (int'(shadow_offset) + int'(req_uv_code >> 1)) % N_TEXELS;
                     sidx = int'(shadow_texel[tidx]) * SHADE_LEVELS + int'(req_light_raw[7:3]);
                     want.value = (sidx < N_SHADES) ? shadow_shade[sidx] : '0;
                     want.written = 1'b1;
                  end
                  pending_pixels.push_back(want);
               end
               default: ;
            endcase
         end
      end
   end

   // Receiver: a fresh random stall after every accepted pixel, plus the long hold.
   always @(posedge clock) begin : receiver
      int draw;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_valid && rsp_ready) begin
         draw = $urandom_range(0, rsp_wait_max);
         rsp_wait <= draw;
         rsp_ready <= (draw == 0) && !rsp_hold;
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1) && !rsp_hold;
      end else begin
         rsp_ready <= !rsp_hold;
      end
   end

   always begin
      @(hold_rsp_ev);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] address,
                            input logic [WDATA_W-1:0] wdata, input logic [UV_W-1:0] uv,
                            input logic [LIGHT_W-1:0] light);
      int gap;
      gap = $urandom_range(0, req_wait_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_address <= address;
      req_write_data <= wdata;
      req_uv_code <= uv;
      req_light_raw <= light;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_texel(input int address, input logic [WDATA_W-1:0] data);
      send_item(uvts_pkg::OP_WR_TEXEL, ADDR_W'(address), data, UV_W'($urandom),
                LIGHT_W'($urandom));
      if (!texel_set[address]) texel_list.push_back(address);
      texel_set[address] = 1'b1;
      texel_plan[address] = data[COLOR_W-1:0];
   endtask

   task automatic write_shade(input int address, input logic [WDATA_W-1:0] rgb);
      send_item(uvts_pkg::OP_WR_SHADE, ADDR_W'(address), rgb, UV_W'($urandom),
                LIGHT_W'($urandom));
      if (address < N_SHADES) shade_set[address] = 1'b1;
   endtask

   // Renders a written texel; wrap picks the UV word that lands on it past the
   // end of the texture, which the lookup must fold back.
   task automatic render_texel(input int texel, input logic [LIGHT_W-1:0] light,
                               input bit wrap);
      int sidx, half;
      sidx = int'(texel_plan[texel]) * SHADE_LEVELS + int'(light[7:3]);
      if (!shade_set[sidx]) write_shade(sidx, WDATA_W'($urandom_range(0, 4095)));
      half = (texel - scroll_offset + N_TEXELS) % N_TEXELS + (wrap ? N_TEXELS : 0);
      send_item(uvts_pkg::OP_RENDER, ADDR_W'($urandom), WDATA_W'($urandom),
                UV_W'(half * 2), light);
   endtask

   task automatic settle_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      // Writes produce no pixel and may still be in flight.
      repeat (PIPE_FLUSH) @(posedge clock);
   endtask

   task automatic write_offset(input logic [OFFSET_W-1:0] value);
      settle_pipeline();
      csr_valid <= 1'b1;
      csr_texture_offset <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      scroll_offset = int'(value);
   endtask

   task automatic random_items(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            write_texel($urandom_range(0, N_TEXELS - 1), WDATA_W'($urandom));
         end else if (pick < 28) begin
            write_shade(($urandom_range(0, 9) == 0) ? $urandom_range(N_SHADES, ADDR_MAX)
                                                    : $urandom_range(0, N_SHADES - 1),
                        WDATA_W'($urandom));
         end else if (pick < 86) begin
            render_texel(texel_list[$urandom_range(0, texel_list.size() - 1)],
                         LIGHT_W'($urandom), 1'($urandom_range(0, 1)));
         end else if (pick < 95) begin
            send_item(uvts_pkg::OP_RENDER, ADDR_W'($urandom), WDATA_W'($urandom),
                      UV_W'($urandom) | UV_W'(1), LIGHT_W'($urandom));
         end else begin
            send_item(OP_UNUSED, ADDR_W'($urandom), WDATA_W'($urandom), UV_W'($urandom),
                      LIGHT_W'($urandom));
         end
      end
   endtask

   task automatic test_directed_cases();
      write_texel(0, 12'hFFF);
      write_texel(ADDR_MAX, 12'h000);
      write_texel(14'h1555, 12'hA5A);
      write_shade(0, 12'h000);
      write_shade(N_SHADES - 1, 12'hFFF);
      write_shade(255 * SHADE_LEVELS, 12'h5A3);
      // Shade addresses past the table are dropped.
      write_shade(N_SHADES, 12'hFFF);
      write_shade(ADDR_MAX, 12'h123);
      send_item(OP_UNUSED, '1, '1, '1, '1);
      send_item(uvts_pkg::OP_RENDER, '1, '1, 16'hFFFF, 8'hFF);
      send_item(uvts_pkg::OP_RENDER, '0, '0, 16'h0001, 8'h00);
      render_texel(0, 8'h00, 1'b0);
      render_texel(0, 8'hFF, 1'b1);
      render_texel(ADDR_MAX, 8'h00, 1'b1);
      render_texel(ADDR_MAX, 8'h07, 1'b0);
      render_texel(14'h1555, 8'h80, 1'b0);
      write_texel(14'h1555, 12'h3C1);
      render_texel(14'h1555, 8'h5F, 1'b1);
   endtask

   task automatic test_texture_scroll();
      logic [OFFSET_W-1:0] offsets [6];
      offsets = '{14'h3FFF, 14'h0000, 14'h0001, 14'h2000, 14'h0000, 14'h3FFF};
      offsets[4] = OFFSET_W'($urandom_range(2, N_TEXELS - 2));
      foreach (offsets[i]) begin
         write_offset(offsets[i]);
         random_items(25);
      end
   endtask

   task automatic test_random_traffic();
      int req_modes [6];
      int rsp_modes [6];
      req_modes = '{0, MAX_WAIT, 0, MAX_WAIT, 3, MAX_WAIT};
      rsp_modes = '{0, 0, MAX_WAIT, MAX_WAIT, 3, MAX_WAIT};
      for (int k = 0; k < 6; k++) begin
         write_offset(OFFSET_W'($urandom_range(0, N_TEXELS - 1)));
         req_wait_max = req_modes[k];
         rsp_wait_max = rsp_modes[k];
         random_items(100);
      end
   endtask

   task automatic test_output_stall();
      settle_pipeline();
      req_wait_max = 0;
      rsp_wait_max = 0;
      -> hold_rsp_ev;
      repeat (60)
         render_texel(texel_list[$urandom_range(0, texel_list.size() - 1)],
                      LIGHT_W'($urandom), 1'($urandom_range(0, 1)));
      req_wait_max = MAX_WAIT;
      rsp_wait_max = MAX_WAIT;
      random_items(60);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_texture_scroll();
      test_random_traffic();
      test_output_stall();
      settle_pipeline();
      if (mismatch_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
